// File: rtl/qrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared types, constants and helpers of the quaternion to rotation matrix
// pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

  // 1.0 in unsigned Q.60 and the half-turn threshold (1e-7 in Q.60)
  localparam logic [63:0] ONE_Q60    = 64'h1000_0000_0000_0000;
  localparam logic [63:0] THRESH_Q60 = 64'd115292150461;
  localparam logic [63:0] HALF_LIMIT = ONE_Q60 - THRESH_Q60;

  // 1.0 in Q.30
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  // One register stage per result bit in the root and quotient units
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 32;

  typedef struct packed {
    logic signed [31:0] quat_b;
    logic signed [31:0] quat_c;
    logic signed [31:0] quat_d;
    logic               left_handed;
  } qrm_in_t;

  typedef struct packed {
    logic signed [31:0] axis1_x;
    logic signed [31:0] axis1_y;
    logic signed [31:0] axis1_z;
    logic signed [31:0] axis2_x;
    logic signed [31:0] axis2_y;
    logic signed [31:0] axis2_z;
    logic signed [31:0] axis3_x;
    logic signed [31:0] axis3_y;
    logic signed [31:0] axis3_z;
    logic               half_turn_case;
  } qrm_out_t;

  // Data that rides along the root and quotient pipelines
  typedef struct packed {
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic               lh;
    logic               half;
  } qrm_side_t;

  // Magnitude of a signed 32-bit value; -2^31 maps to 2^31
  function automatic logic [31:0] mag32(logic signed [31:0] x);
    logic [31:0] r;
    r = x[31] ? (~x + 32'd1) : x;
    return r;
  endfunction

endpackage

// File: rtl/quaternion_to_rotation_matrix_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_top
// Unit quaternion vector part (Q2.30) to a saturated Q2.30 rotation matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries b, c, d and the
//   handedness flag; output channel out_valid_o / out_stall_i / out_data_o
//   carries the nine matrix entries and the half-turn flag. A beat moves when
//   valid is high and stall is low.
//   Path: an accepted input beat passes the squares and sum stages, the
//   bit-per-stage root, the dividend stage and bit-per-stage divider, then
//   select, products, quartering, sums and rounding into the output register.
//   Throughput: one beat per cycle while in_stall_o is low; no stage
//   iterates, so a new beat enters every cycle unless the input is stalled.
//   Stall: while the output register holds an untaken result, the pipeline
//   keeps filling; it halts only when its last stage also holds a result,
//   and then in_stall_o rises. Nothing is dropped or repeated.
//   Reset: all valid bits clear; the pipeline is empty and ready at once.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qrm_pkg::qrm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qrm_pkg::qrm_out_t out_data_o
);
  import qrm_pkg::*;

  // Q.30 x Q.30 exact product
  function automatic logic signed [63:0] mul64(logic signed [31:0] x,
                                               logic signed [31:0] y);
    logic signed [63:0] p;
    p = 64'(x) * 64'(y);
    return p;
  endfunction

  // Q.60 to Q.58, toward zero
  function automatic logic signed [63:0] quarter(logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + (p[63] ? 64'sd3 : 64'sd0)) >>> 2;
    return r;
  endfunction

  // Q.58 to Q.30, halves away from zero, saturated
  function automatic logic signed [31:0] to_q30(logic signed [63:0] v);
    logic [63:0] m;
    logic [35:0] r;
    logic [31:0] o;
    m = v[63] ? (~v + 64'd1) : v;
    r = 36'((m + 64'h0800_0000) >> 28);
    if (!v[63]) begin
      o = (r > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    end else begin
      o = (r > 36'h0_8000_0000) ? 32'h8000_0000 : (~r[31:0] + 32'd1);
    end
    return o;
  endfunction

  logic en;
  logic load_out;

  // stage 1: squares of the magnitudes
  logic        v1_q;
  logic [63:0] sqb_q, sqc_q, sqd_q;
  qrm_side_t   side1_q;
  logic [31:0] mb, mc, md;

  // stage 2: sum, threshold, radicand
  logic        v2_q;
  logic [63:0] rad2_q;
  qrm_side_t   side2_q;
  logic [63:0] sum2;
  logic        half2;

  // root and divider
  logic             sv_valid;
  logic [31:0]      sv_root;
  qrm_side_t        sv_side;
  logic             dv_valid;
  logic [31:0]      dv_n;
  logic [2:0][31:0] dv_quo;
  qrm_side_t        dv_side;

  // stage 3: final a, b, c, d
  logic                  v3_q;
  logic signed [31:0]    a3_q, b3_q, c3_q, d3_q;
  logic                  lh3_q, half3_q;

  // stage 4: products; stage 5: quartered products
  logic                  v4_q, v5_q;
  logic                  lh4_q, half4_q, lh5_q, half5_q;
  logic signed [63:0]    p4_q [10];
  logic signed [63:0]    p5_q [10];

  // stage 6: matrix sums
  logic                  v6_q;
  logic                  half6_q;
  logic signed [63:0]    e6_q [9];
  logic signed [63:0]    e6_d [9];

  // output register
  logic     out_valid_q;
  qrm_out_t out_q;

  // advance unless the last stage is blocked by a held result
  assign en         = !(v6_q && out_valid_q && out_stall_i);
  assign load_out   = v6_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !en;

  assign mb = mag32(in_data_i.quat_b);
  assign mc = mag32(in_data_i.quat_c);
  assign md = mag32(in_data_i.quat_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= dv_valid;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // square the magnitudes
  always_ff @(posedge clk_i) begin
    if (en) begin
      sqb_q        <= 64'(mb) * 64'(mb);
      sqc_q        <= 64'(mc) * 64'(mc);
      sqd_q        <= 64'(md) * 64'(md);
      side1_q.b    <= in_data_i.quat_b;
      side1_q.c    <= in_data_i.quat_c;
      side1_q.d    <= in_data_i.quat_d;
      side1_q.lh   <= in_data_i.left_handed;
      side1_q.half <= 1'b0;
    end
  end

  // pick the half-turn path and the radicand
  assign sum2  = sqb_q + sqc_q + sqd_q;
  assign half2 = (sum2 > HALF_LIMIT);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad2_q       <= half2 ? sum2 : (ONE_Q60 - sum2);
      side2_q.b    <= side1_q.b;
      side2_q.c    <= side1_q.c;
      side2_q.d    <= side1_q.d;
      side2_q.lh   <= side1_q.lh;
      side2_q.half <= half2;
    end
  end

  qrm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .rad_i   (rad2_q),
    .side_i  (side2_q),
    .valid_o (sv_valid),
    .root_o  (sv_root),
    .side_o  (sv_side)
  );

  qrm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv_valid),
    .n_i     (sv_root),
    .side_i  (sv_side),
    .valid_o (dv_valid),
    .n_o     (dv_n),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // select normalized or original components
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dv_side.half) begin
        a3_q <= '0;
        b3_q <= dv_side.b[31] ? -$signed(dv_quo[0]) : $signed(dv_quo[0]);
        c3_q <= dv_side.c[31] ? -$signed(dv_quo[1]) : $signed(dv_quo[1]);
        d3_q <= dv_side.d[31] ? -$signed(dv_quo[2]) : $signed(dv_quo[2]);
      end else begin
        a3_q <= $signed(dv_n);
        b3_q <= dv_side.b;
        c3_q <= dv_side.c;
        d3_q <= dv_side.d;
      end
      lh3_q   <= dv_side.lh;
      half3_q <= dv_side.half;
    end
  end

  // products: aa bb cc dd bc ad bd ac cd ab
  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_q[0] <= mul64(a3_q, a3_q);
      p4_q[1] <= mul64(b3_q, b3_q);
      p4_q[2] <= mul64(c3_q, c3_q);
      p4_q[3] <= mul64(d3_q, d3_q);
      p4_q[4] <= mul64(b3_q, c3_q);
      p4_q[5] <= mul64(a3_q, d3_q);
      p4_q[6] <= mul64(b3_q, d3_q);
      p4_q[7] <= mul64(a3_q, c3_q);
      p4_q[8] <= mul64(c3_q, d3_q);
      p4_q[9] <= mul64(a3_q, b3_q);
      lh4_q   <= lh3_q;
      half4_q <= half3_q;
    end
  end

  // reduce to Q.58
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 10; i++) begin
        p5_q[i] <= quarter(p4_q[i]);
      end
      lh5_q   <= lh4_q;
      half5_q <= half4_q;
    end
  end

  // form the nine entries, negate the z component of each axis for left-handed frames
  always_comb begin
    e6_d[0] = p5_q[0] + p5_q[1] - p5_q[2] - p5_q[3];
    e6_d[1] = (p5_q[4] - p5_q[5]) <<< 1;
    e6_d[2] = (p5_q[6] + p5_q[7]) <<< 1;
    e6_d[3] = (p5_q[4] + p5_q[5]) <<< 1;
    e6_d[4] = p5_q[0] + p5_q[2] - p5_q[1] - p5_q[3];
    e6_d[5] = (p5_q[8] - p5_q[9]) <<< 1;
    e6_d[6] = (p5_q[6] - p5_q[7]) <<< 1;
    e6_d[7] = (p5_q[8] + p5_q[9]) <<< 1;
    e6_d[8] = p5_q[0] + p5_q[3] - p5_q[2] - p5_q[1];
    if (lh5_q) begin
      e6_d[2] = -e6_d[2];
      e6_d[5] = -e6_d[5];
      e6_d[8] = -e6_d[8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e6_q    <= e6_d;
      half6_q <= half5_q;
    end
  end

  // output register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.axis1_x        <= to_q30(e6_q[0]);
      out_q.axis1_y        <= to_q30(e6_q[1]);
      out_q.axis1_z        <= to_q30(e6_q[2]);
      out_q.axis2_x        <= to_q30(e6_q[3]);
      out_q.axis2_y        <= to_q30(e6_q[4]);
      out_q.axis2_z        <= to_q30(e6_q[5]);
      out_q.axis3_x        <= to_q30(e6_q[6]);
      out_q.axis3_y        <= to_q30(e6_q[7]);
      out_q.axis3_z        <= to_q30(e6_q[8]);
      out_q.half_turn_case <= half6_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // input halts only behind a held result with a full last stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && v6_q))
    else $error("input stalled without a blocked pipeline tail");

  // scalar part of a unit quaternion never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sv_valid && !sv_side.half) |-> (sv_root <= ONE_Q30))
    else $error("root above one on the normal path");

  // normalized components never exceed one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_valid && dv_side.half) |->
      ((dv_quo[0] <= ONE_Q30) && (dv_quo[1] <= ONE_Q30) && (dv_quo[2] <= ONE_Q30)))
    else $error("normalized component above one");

endmodule

// File: rtl/qrm_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_sqrt
// Pipelined integer square root, floor(sqrt(x)) of a 64-bit radicand, one
// result bit per register stage.
// ----------------------------------------------------------------------------
module qrm_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [63:0]         rad_i,
  input  qrm_pkg::qrm_side_t  side_i,
  output logic                valid_o,
  output logic [31:0]         root_o,
  output qrm_pkg::qrm_side_t  side_o
);
  import qrm_pkg::*;

  logic        v_q    [SQRT_STEPS];
  logic [63:0] rad_q  [SQRT_STEPS];
  logic [33:0] rem_q  [SQRT_STEPS];
  logic [31:0] root_q [SQRT_STEPS];
  qrm_side_t   side_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic        src_v;
    logic [63:0] src_rad;
    logic [33:0] src_rem;
    logic [31:0] src_root;
    qrm_side_t   src_side;
    logic [35:0] cur;
    logic [35:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign src_v    = valid_i;
      assign src_rad  = rad_i;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_side = side_i;
    end else begin : g_next
      assign src_v    = v_q[k-1];
      assign src_rad  = rad_q[k-1];
      assign src_rem  = rem_q[k-1];
      assign src_root = root_q[k-1];
      assign src_side = side_q[k-1];
    end

    // bring down two radicand bits, try 4*root+1
    assign cur   = {src_rem, src_rad[63:62]};
    assign trial = {2'b00, src_root, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {src_rad[61:0], 2'b00};
        rem_q[k]  <= ge ? 34'(cur - trial) : cur[33:0];
        root_q[k] <= {src_root[30:0], ge};
        side_q[k] <= src_side;
      end
    end
  end

  assign valid_o = v_q[SQRT_STEPS-1];
  assign root_o  = root_q[SQRT_STEPS-1];
  assign side_o  = side_q[SQRT_STEPS-1];

endmodule

// File: rtl/qrm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_div
// Three-lane pipelined divider: each vector component magnitude times 2^30,
// plus half the divisor, over the vector length; one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [31:0]         n_i,
  input  qrm_pkg::qrm_side_t  side_i,
  output logic                valid_o,
  output logic [31:0]         n_o,
  output logic [2:0][31:0]    quo_o,
  output qrm_pkg::qrm_side_t  side_o
);
  import qrm_pkg::*;

  logic [2:0][31:0] mag;
  logic             pv_q;
  logic [2:0][62:0] num_q;
  logic [31:0]      pn_q;
  qrm_side_t        pside_q;

  logic             v_q    [DIV_STEPS];
  logic [2:0][31:0] rem_q  [DIV_STEPS];
  logic [2:0][31:0] low_q  [DIV_STEPS];
  logic [2:0][31:0] quo_q  [DIV_STEPS];
  logic [31:0]      n_q    [DIV_STEPS];
  qrm_side_t        side_q [DIV_STEPS];

  assign mag[0] = mag32(side_i.b);
  assign mag[1] = mag32(side_i.c);
  assign mag[2] = mag32(side_i.d);

  // form the rounded dividends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        num_q[l] <= 63'({mag[l], 30'b0}) + 63'(n_i[31:1]);
      end
      pn_q    <= n_i;
      pside_q <= side_i;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic             src_v;
    logic [2:0][31:0] src_rem;
    logic [2:0][31:0] src_low;
    logic [2:0][31:0] src_quo;
    logic [31:0]      src_n;
    qrm_side_t        src_side;
    logic [2:0][31:0] rem_d;
    logic [2:0]       ge;

    if (k == 0) begin : g_first
      assign src_v = pv_q;
      for (genvar l = 0; l < 3; l++) begin : g_init
        assign src_rem[l] = {1'b0, num_q[l][62:32]};
        assign src_low[l] = num_q[l][31:0];
      end
      assign src_quo  = '0;
      assign src_n    = pn_q;
      assign src_side = pside_q;
    end else begin : g_next
      assign src_v    = v_q[k-1];
      assign src_rem  = rem_q[k-1];
      assign src_low  = low_q[k-1];
      assign src_quo  = quo_q[k-1];
      assign src_n    = n_q[k-1];
      assign src_side = side_q[k-1];
    end

    // shift in one dividend bit per lane, subtract when it fits
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [32:0] cur;
      assign cur      = {src_rem[l], src_low[l][31]};
      assign ge[l]    = (cur >= {1'b0, src_n});
      assign rem_d[l] = ge[l] ? 32'(cur - {1'b0, src_n}) : cur[31:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 3; l++) begin
          rem_q[k][l] <= rem_d[l];
          low_q[k][l] <= {src_low[l][30:0], 1'b0};
          quo_q[k][l] <= {src_quo[l][30:0], ge[l]};
        end
        n_q[k]    <= src_n;
        side_q[k] <= src_side;
      end
    end
  end

  assign valid_o = v_q[DIV_STEPS-1];
  assign n_o     = n_q[DIV_STEPS-1];
  assign quo_o   = quo_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];

endmodule

// File: tb/sv/quaternion_to_rotation_matrix_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_top_tb
// Self-checking bench for the quaternion to rotation matrix pipeline. The
// bench drives directed and random quaternion beats with bursty valid and
// patterned output stall. An in-bench fixed-point model predicts every
// matrix, and a scoreboard compares each output beat field by field.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_top_tb;
  import qrm_pkg::*;

  localparam int unsigned LATENCY = 72;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  qrm_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  qrm_out_t out_data_o;

  qrm_in_t  quat_queue[$];
  qrm_out_t matrix_queue[$];
  int       error_count = 0;
  bit       hold_send = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       stall_phase = 0;

  quaternion_to_rotation_matrix_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Bitwise integer square root, floor
  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Scale one component to unit length, rounded half away from zero
  function automatic longint unit_scale(longint x, logic [63:0] n);
    logic [63:0] m;
    logic [63:0] q;
    m = (x < 0) ? -x : x;
    q = ((m << 30) + (n >> 1)) / n;
    return (x < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint prod_q58(longint x, longint y);
    return (x * y) / 4;
  endfunction

  // Round Q.58 to Q.30 half away from zero and saturate
  function automatic logic signed [31:0] round_sat(longint v);
    logic [63:0] m;
    longint r;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << 27)) >> 28;
    r = (v < 0) ? -longint'(m) : longint'(m);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic qrm_out_t predict_matrix(qrm_in_t q);
    qrm_out_t res;
    longint b, c, d, a;
    longint aa, bb, cc, dd, bc, ad, bd, ac, cd, ab, e1z, e2z, e3z;
    logic [63:0] bm, cm, dm, s, n;
    bit half;
    b = q.quat_b;
    c = q.quat_c;
    d = q.quat_d;
    bm = (b < 0) ? -b : b;
    cm = (c < 0) ? -c : c;
    dm = (d < 0) ? -d : d;
    s = bm * bm + cm * cm + dm * dm;
    half = s > HALF_LIMIT;
    if (half) begin
      n = root_floor(s);
      b = unit_scale(b, n);
      c = unit_scale(c, n);
      d = unit_scale(d, n);
      a = 0;
    end else begin
      a = root_floor(ONE_Q60 - s);
    end
    aa = prod_q58(a, a); bb = prod_q58(b, b); cc = prod_q58(c, c);
    dd = prod_q58(d, d); bc = prod_q58(b, c); ad = prod_q58(a, d);
    bd = prod_q58(b, d); ac = prod_q58(a, c); cd = prod_q58(c, d);
    ab = prod_q58(a, b);
    e1z = 2 * (bd + ac);
    e2z = 2 * (cd - ab);
    e3z = aa + dd - cc - bb;
    if (q.left_handed) begin
      e1z = -e1z;
      e2z = -e2z;
      e3z = -e3z;
    end
    res.axis1_x = round_sat(aa + bb - cc - dd);
    res.axis1_y = round_sat(2 * (bc - ad));
    res.axis1_z = round_sat(e1z);
    res.axis2_x = round_sat(2 * (bc + ad));
    res.axis2_y = round_sat(aa + cc - bb - dd);
    res.axis2_z = round_sat(e2z);
    res.axis3_x = round_sat(2 * (bd - ac));
    res.axis3_y = round_sat(2 * (cd + ab));
    res.axis3_z = round_sat(e3z);
    res.half_turn_case = half;
    return res;
  endfunction

  function automatic qrm_in_t make_quat(int b, int c, int d, bit lh);
    qrm_in_t q;
    q.quat_b = b;
    q.quat_c = c;
    q.quat_d = d;
    q.left_handed = lh;
    return q;
  endfunction

  // Random component: mostly within +-0.5 or +-1.0 in Q2.30, else any 32-bit value
  function automatic int rand_comp();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
    if (sel < 8) return int'($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000;
    return int'($urandom());
  endfunction

  // Drive beats in bursts with random gaps; hold while paused
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        matrix_queue.push_back(predict_matrix(in_data_i));
      end
      if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (quat_queue.size() > 0 && !hold_send) begin
        in_valid_i <= 1'b1;
        in_data_i  <= quat_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall output on a rotating pattern with stall-free stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 400;
      if (stall_phase < 100) out_stall_i <= 1'b0;
      else if (stall_phase < 200) out_stall_i <= ($urandom_range(0, 3) == 0);
      else if (stall_phase < 300) out_stall_i <= (stall_phase % 7) < 4;
      else out_stall_i <= ($urandom_range(0, 9) < 8);
    end
  end

  // Check each output beat against the oldest prediction
  always @(posedge clk_i) begin
    qrm_out_t exp_m;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (matrix_queue.size() == 0) begin
        $error("unexpected output beat");
        error_count++;
      end else begin
        exp_m = matrix_queue.pop_front();
        if (out_data_o.axis1_x !== exp_m.axis1_x) begin
          $error("axis1_x exp %0d got %0d", exp_m.axis1_x, out_data_o.axis1_x);
          error_count++;
        end
        if (out_data_o.axis1_y !== exp_m.axis1_y) begin
          $error("axis1_y exp %0d got %0d", exp_m.axis1_y, out_data_o.axis1_y);
          error_count++;
        end
        if (out_data_o.axis1_z !== exp_m.axis1_z) begin
          $error("axis1_z exp %0d got %0d", exp_m.axis1_z, out_data_o.axis1_z);
          error_count++;
        end
        if (out_data_o.axis2_x !== exp_m.axis2_x) begin
          $error("axis2_x exp %0d got %0d", exp_m.axis2_x, out_data_o.axis2_x);
          error_count++;
        end
        if (out_data_o.axis2_y !== exp_m.axis2_y) begin
          $error("axis2_y exp %0d got %0d", exp_m.axis2_y, out_data_o.axis2_y);
          error_count++;
        end
        if (out_data_o.axis2_z !== exp_m.axis2_z) begin
          $error("axis2_z exp %0d got %0d", exp_m.axis2_z, out_data_o.axis2_z);
          error_count++;
        end
        if (out_data_o.axis3_x !== exp_m.axis3_x) begin
          $error("axis3_x exp %0d got %0d", exp_m.axis3_x, out_data_o.axis3_x);
          error_count++;
        end
        if (out_data_o.axis3_y !== exp_m.axis3_y) begin
          $error("axis3_y exp %0d got %0d", exp_m.axis3_y, out_data_o.axis3_y);
          error_count++;
        end
        if (out_data_o.axis3_z !== exp_m.axis3_z) begin
          $error("axis3_z exp %0d got %0d", exp_m.axis3_z, out_data_o.axis3_z);
          error_count++;
        end
        if (out_data_o.half_turn_case !== exp_m.half_turn_case) begin
          $error("half_turn_case exp %0b got %0b", exp_m.half_turn_case,
                 out_data_o.half_turn_case);
          error_count++;
        end
      end
    end
  end

  // Timeout
  initial begin
    #(5_000_000);
    $display("** quaternion_to_rotation_matrix_top: FAILED **");
    $finish;
  end

  initial begin
    int i;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: identity, axes, half turns, extremes, threshold edge
    quat_queue.push_back(make_quat(0, 0, 0, 0));
    quat_queue.push_back(make_quat(0, 0, 0, 1));
    quat_queue.push_back(make_quat(32'sh4000_0000, 0, 0, 0));
    quat_queue.push_back(make_quat(0, 32'sh4000_0000, 0, 1));
    quat_queue.push_back(make_quat(0, 0, -32'sh4000_0000, 0));
    quat_queue.push_back(make_quat(32'sh2d41_3ccd, 32'sh2d41_3ccd, 0, 0));
    quat_queue.push_back(make_quat(32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000, 1));
    quat_queue.push_back(make_quat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0));
    quat_queue.push_back(make_quat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1));
    quat_queue.push_back(make_quat(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0));
    quat_queue.push_back(make_quat(-1, -1, -1, 1));
    quat_queue.push_back(make_quat(1, 0, 0, 0));
    quat_queue.push_back(make_quat(32'sh3FFF_FFF0, 0, 0, 0));
    quat_queue.push_back(make_quat(32'sh3FFF_FE00, 0, 0, 1));
    quat_queue.push_back(make_quat(32'sh3FFF_F000, 0, 0, 0));
    quat_queue.push_back(make_quat(0, 32'sh3FFF_FF00, 32'sh0000_4000, 1));
    quat_queue.push_back(make_quat(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 0));

    for (i = 0; i < 600; i++) begin
      quat_queue.push_back(make_quat(rand_comp(), rand_comp(), rand_comp(),
                                     $urandom_range(0, 1)));
    end

    // Pause midway until every expected result has come
    wait (quat_queue.size() <= 300);
    hold_send = 1;
    while (in_valid_i || matrix_queue.size() > 0) @(posedge clk_i);
    hold_send = 0;

    while (quat_queue.size() > 0 || in_valid_i) @(posedge clk_i);
    while (matrix_queue.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** quaternion_to_rotation_matrix_top: PASSED **");
    end else begin
      $display("** quaternion_to_rotation_matrix_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/qrm_pkg.sv
rtl/qrm_sqrt.sv
rtl/qrm_div.sv
rtl/quaternion_to_rotation_matrix_top.sv
tb/sv/quaternion_to_rotation_matrix_top_tb.sv
